### src/spc_pkg.sv
// shared types and constants for the shortest path counter
// no dependencies
`default_nettype none
package spc_pkg;
	localparam int NodeW     = 10;
	localparam int MaxNodes  = 1024;
	localparam int MaxEdges  = 8192;
	localparam int EdgeW     = 13;
	localparam int LinkW     = 14;
	localparam int DistW     = 11;
	localparam int PathW     = 17;
	localparam int LinkEntW  = NodeW + LinkW;
	localparam logic [PathW-1:0] PathMod = 17'd100003;
	localparam logic [DistW-1:0] DistInf = 11'd2047;
	localparam logic [LinkW-1:0] FillMax = 14'd8190;

	typedef enum logic [1:0] {
		ACT_ADD  = 2'd0,
		ACT_RUN  = 2'd1,
		ACT_READ = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;
endpackage
`default_nettype wire

### src/spc_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none
module spc_ram #(
	parameter int W = 8,
	parameter int D = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### src/shortest_path_count_bfs.sv
// top level: edge loader, breadth first walk and result read
// depends on spc_pkg and spc_ram
`default_nettype none
// channel  | dir | tdata fields (low bit up)                      | tuser
// s_axis   | in  | action[1:0] node_a[11:2] node_b[21:12]         | none
// m_axis   | out | status[1:0] path_count[18:2] hop_distance[28:19] reachable[29] | none
// cfg      | in  | node_count in cfg_wr_data, written on cfg_wr_en | none
//
// add edge: S_ADD1, S_ADD2; read: S_RD1; then S_FIN loads the output register
// run: S_CLR clears distances, then per visited node S_POP, S_POP2, S_POP3, S_EDGE
//   and per stored link S_EDG2, S_EDG3, S_EDGE (single ports of link and node memories)
// after reset a pass in S_RCLR clears list heads and distances; no input taken
// a result waiting on m_tready holds the block in its finish state
module shortest_path_count_bfs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // action, node_a, node_b
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // status, path_count, hop_distance, reachable
	input  wire logic        cfg_wr_en,
	input  wire logic [9:0]  cfg_wr_data
);
	typedef enum logic [3:0] {
		S_RCLR, S_IDLE, S_ADD1, S_ADD2, S_CLR, S_INIT, S_POP, S_POP2,
		S_POP3, S_EDGE, S_EDG2, S_EDG3, S_RD1, S_FIN
	} state_t;

	state_t state_q;
	logic [spc_pkg::NodeW-1:0] node_count_q;
	logic [1:0] act_q;
	logic [spc_pkg::NodeW-1:0] a_q, b_q, x_q, y_q, cnt_q;
	logic [spc_pkg::LinkW-1:0] fill_q, e_q;
	logic [spc_pkg::NodeW:0] rd_q, wr_q;
	logic [spc_pkg::DistW-1:0] nd_q;
	logic [spc_pkg::PathW-1:0] px_q;
	logic [1:0] res_status_q;
	logic [spc_pkg::PathW-1:0] res_count_q;
	logic [spc_pkg::NodeW-1:0] res_dist_q;
	logic res_reach_q;
	logic [31:0] out_q;
	logic out_v_q;

	// memory ports
	logic hd_we, ln_we, ds_we, pt_we, ff_we;
	logic [spc_pkg::NodeW-1:0] hd_wa, hd_ra, ds_wa, ds_ra, pt_wa, pt_ra, ff_wa, ff_ra;
	logic [spc_pkg::EdgeW-1:0] ln_wa, ln_ra;
	logic [spc_pkg::LinkW-1:0] hd_wd, hd_rd;
	logic [spc_pkg::LinkEntW-1:0] ln_wd, ln_rd;
	logic [spc_pkg::DistW-1:0] ds_wd, ds_rd;
	logic [spc_pkg::PathW-1:0] pt_wd, pt_rd;
	logic [spc_pkg::NodeW-1:0] ff_wd, ff_rd;

	logic [1:0] in_act;
	logic [spc_pkg::NodeW-1:0] in_a, in_b;
	logic a_ok, b_ok;
	logic [spc_pkg::PathW:0] psum;
	logic [spc_pkg::PathW-1:0] pmod;
	logic [spc_pkg::LinkW-1:0] hb;
	logic out_load;

	assign in_act = s_tdata[1:0];
	assign in_a   = s_tdata[11:2];
	assign in_b   = s_tdata[21:12];
	assign a_ok   = (in_a != '0) && (in_a <= node_count_q);
	assign b_ok   = (in_b != '0) && (in_b <= node_count_q);
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;
	// output register takes a new result when empty or draining
	assign out_load = (state_q == S_FIN) && (!out_v_q || m_tready);

	// modular accumulate, operands already below the modulus
	assign psum = {1'b0, ds_rd == nd_q ? pt_rd : '0} + {1'b0, px_q};
	assign pmod = (psum >= {1'b0, spc_pkg::PathMod}) ?
		spc_pkg::PathW'(psum - {1'b0, spc_pkg::PathMod}) : psum[spc_pkg::PathW-1:0];
	// second half of an add: forward the head just written for a self loop
	assign hb = (a_q == b_q) ? spc_pkg::LinkW'(fill_q + 14'd1) : hd_rd;

	spc_ram #(.W(spc_pkg::LinkW), .D(spc_pkg::MaxNodes)) u_heads (
		.clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
	spc_ram #(.W(spc_pkg::LinkEntW), .D(spc_pkg::MaxEdges)) u_links (
		.clk, .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(ln_ra), .rdata(ln_rd));
	spc_ram #(.W(spc_pkg::DistW), .D(spc_pkg::MaxNodes)) u_dist (
		.clk, .we(ds_we), .waddr(ds_wa), .wdata(ds_wd), .raddr(ds_ra), .rdata(ds_rd));
	spc_ram #(.W(spc_pkg::PathW), .D(spc_pkg::MaxNodes)) u_paths (
		.clk, .we(pt_we), .waddr(pt_wa), .wdata(pt_wd), .raddr(pt_ra), .rdata(pt_rd));
	spc_ram #(.W(spc_pkg::NodeW), .D(spc_pkg::MaxNodes)) u_fifo (
		.clk, .we(ff_we), .waddr(ff_wa), .wdata(ff_wd), .raddr(ff_ra), .rdata(ff_rd));

	// memory addressing per state
	always_comb begin
		hd_we = 1'b0; hd_wa = a_q; hd_wd = '0; hd_ra = in_a;
		ln_we = 1'b0; ln_wa = fill_q[spc_pkg::EdgeW-1:0]; ln_wd = '0;
		ln_ra = spc_pkg::EdgeW'(e_q - 14'd1);
		ds_we = 1'b0; ds_wa = cnt_q; ds_wd = spc_pkg::DistInf; ds_ra = in_a;
		pt_we = 1'b0; pt_wa = a_q; pt_wd = '0; pt_ra = in_a;
		ff_we = 1'b0; ff_wa = wr_q[spc_pkg::NodeW-1:0]; ff_wd = y_q;
		ff_ra = rd_q[spc_pkg::NodeW-1:0];
		case (state_q)
			S_RCLR: begin
				hd_we = 1'b1; hd_wa = cnt_q;
				ds_we = 1'b1;
			end
			S_ADD1: begin
				ln_we = 1'b1; ln_wd = {hd_rd, b_q};
				hd_we = 1'b1; hd_wd = spc_pkg::LinkW'(fill_q + 14'd1);
				hd_ra = b_q;
			end
			S_ADD2: begin
				ln_we = 1'b1; ln_wa = spc_pkg::EdgeW'(fill_q + 14'd1);
				ln_wd = {hb, a_q};
				hd_we = 1'b1; hd_wa = b_q; hd_wd = spc_pkg::LinkW'(fill_q + 14'd2);
			end
			S_CLR: ds_we = 1'b1;
			S_INIT: begin
				ds_we = 1'b1; ds_wa = a_q; ds_wd = '0;
				pt_we = 1'b1; pt_wd = spc_pkg::PathW'(1);
				ff_we = 1'b1; ff_wa = '0; ff_wd = a_q;
			end
			S_POP2: begin
				hd_ra = ff_rd; ds_ra = ff_rd; pt_ra = ff_rd;
			end
			S_EDG2: begin
				ds_ra = ln_rd[spc_pkg::NodeW-1:0];
				pt_ra = ln_rd[spc_pkg::NodeW-1:0];
			end
			S_EDG3: begin
				// first discovery sets distance and count and queues the node
				if (ds_rd == spc_pkg::DistInf) begin
					ds_we = 1'b1; ds_wa = y_q; ds_wd = nd_q;
					pt_we = 1'b1; pt_wa = y_q; pt_wd = px_q;
					ff_we = 1'b1;
				end else if (ds_rd == nd_q) begin
					pt_we = 1'b1; pt_wa = y_q; pt_wd = pmod;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RCLR;
			node_count_q <= 10'd1023;
			cnt_q <= '0;
			fill_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
			act_q <= '0; a_q <= '0; b_q <= '0; x_q <= '0; y_q <= '0;
			e_q <= '0; rd_q <= '0; wr_q <= '0; nd_q <= '0; px_q <= '0;
			res_status_q <= '0; res_count_q <= '0; res_dist_q <= '0; res_reach_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				node_count_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_RCLR: begin
					cnt_q <= cnt_q + 10'd1;
					if (cnt_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_tvalid) begin
						act_q <= in_act; a_q <= in_a; b_q <= in_b;
						res_status_q <= spc_pkg::ST_OK;
						res_count_q <= '0; res_dist_q <= '0; res_reach_q <= 1'b0;
						cnt_q <= '0;
						state_q <= S_FIN;
						case (in_act)
							spc_pkg::ACT_ADD: begin
								if (!a_ok || !b_ok) res_status_q <= spc_pkg::ST_RANGE;
								else if (fill_q > spc_pkg::FillMax)
									res_status_q <= spc_pkg::ST_FULL;
								else state_q <= S_ADD1;
							end
							spc_pkg::ACT_RUN: begin
								if (!a_ok) res_status_q <= spc_pkg::ST_RANGE;
								else state_q <= S_CLR;
							end
							spc_pkg::ACT_READ: begin
								if (!a_ok) res_status_q <= spc_pkg::ST_RANGE;
								else state_q <= S_RD1;
							end
							default: ;
						endcase
					end
				end
				S_ADD1: state_q <= S_ADD2;
				S_ADD2: begin
					fill_q <= spc_pkg::LinkW'(fill_q + 14'd2);
					state_q <= S_FIN;
				end
				S_CLR: begin
					cnt_q <= cnt_q + 10'd1;
					if (cnt_q == '1) state_q <= S_INIT;
				end
				S_INIT: begin
					rd_q <= '0;
					wr_q <= 11'd1;
					state_q <= S_POP;
				end
				S_POP: begin
					if (rd_q == wr_q) begin
						state_q <= S_FIN;
					end else begin
						rd_q <= rd_q + 11'd1;
						state_q <= S_POP2;
					end
				end
				S_POP2: begin
					x_q <= ff_rd;
					state_q <= S_POP3;
				end
				S_POP3: begin
					e_q <= hd_rd;
					nd_q <= ds_rd + 11'd1;
					px_q <= pt_rd;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					if (e_q == '0) state_q <= S_POP;
					else state_q <= S_EDG2;
				end
				S_EDG2: begin
					y_q <= ln_rd[spc_pkg::NodeW-1:0];
					e_q <= ln_rd[spc_pkg::LinkEntW-1:spc_pkg::NodeW];
					state_q <= S_EDG3;
				end
				S_EDG3: begin
					if (ds_rd == spc_pkg::DistInf) wr_q <= wr_q + 11'd1;
					state_q <= S_EDGE;
				end
				S_RD1: begin
					if (ds_rd != spc_pkg::DistInf) begin
						res_count_q <= pt_rd;
						res_dist_q <= ds_rd[spc_pkg::NodeW-1:0];
						res_reach_q <= 1'b1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					// load the output register once it is free
					if (out_load) begin
						out_q <= {2'b00, res_reach_q, res_dist_q, res_count_q, res_status_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic unused_x;
	assign unused_x = ^{x_q, act_q, s_tdata[23:22]};
endmodule
`default_nettype wire

### src/spc_checker.sv
// port level checks for the shortest path counter
// depends on spc_pkg; bound to shortest_path_count_bfs
`default_nettype none
module spc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != spc_pkg::ST_RSVD)
		else $error("reserved status");
	a_unreach: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[29] |-> m_tdata[18:2] == '0 && m_tdata[28:19] == '0)
		else $error("unreached result with data");
	a_mod: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[29] |-> m_tdata[18:2] < spc_pkg::PathMod
			&& m_tdata[1:0] == spc_pkg::ST_OK)
		else $error("bad reached result");
endmodule

bind shortest_path_count_bfs spc_checker u_spc_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata));
`default_nettype wire
